// ===== src/glyph_skip_color_rle_decoder_macros.svh =====
// ----------------------------------------------------------------------------
// glyph skip/colour rle decoder: assertion macros
// concurrent checks on clk, held off while arst_n is low
// ----------------------------------------------------------------------------
`ifndef GLYPH_SKIP_COLOR_RLE_DECODER_MACROS_SVH
`define GLYPH_SKIP_COLOR_RLE_DECODER_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define GSCRD_ASSERT_IMP(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// next-cycle implication
`define GSCRD_ASSERT_NXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`else

`define GSCRD_ASSERT_IMP(lbl, pre, post, msg)
`define GSCRD_ASSERT_NXT(lbl, pre, post, msg)

`endif

`endif

// ===== src/gscrd_pkg.sv =====
// ----------------------------------------------------------------------------
// gscrd_pkg
// shared types and constants of the glyph skip/colour rle decoder
// ----------------------------------------------------------------------------
`default_nettype none

package gscrd_pkg;

	// code byte layout
	localparam logic [7:0] SKIP_MASK  = 8'hF8;
	localparam logic [7:0] COLOR_MASK = 8'h07;
	localparam int unsigned SKIP_SHIFT = 3;

	localparam int unsigned SKIP_W  = 5;
	localparam int unsigned COLOR_W = 3;
	localparam int unsigned COORD_W = 8;
	localparam int unsigned CFG_IDX_W = 2;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BOX_WIDTH    = 2'd0,
		REG_BOX_HEIGHT   = 2'd1,
		REG_BOX_X_OFFSET = 2'd2,
		REG_BOX_Y_OFFSET = 2'd3
	} cfg_reg_t;

	// classified byte passed from front to back
	typedef struct packed {
		logic [SKIP_W-1:0]  skip;
		logic [COLOR_W-1:0] color;
	} cmd_t;

	// box geometry
	typedef struct packed {
		logic [COORD_W-1:0] width;
		logic [COORD_W-1:0] height;
		logic [COORD_W-1:0] x_off;
		logic [COORD_W-1:0] y_off;
	} box_cfg_t;

	// one output pixel
	typedef struct packed {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [COLOR_W-1:0] color;
		logic               last;
		logic               done;
	} pixel_t;

endpackage

`default_nettype wire

// ===== src/gscrd_front.sv =====
// ----------------------------------------------------------------------------
// gscrd_front
// accepts code bytes, splits them into skip count and colour, queues them
// ----------------------------------------------------------------------------
`default_nettype none

module gscrd_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	output logic               full,
	input  wire logic [7:0]    code_byte,
	output gscrd_pkg::cmd_t    cmd,
	output logic               cmd_valid,
	input  wire logic          cmd_take
);
	import gscrd_pkg::*;

	cmd_t       q_mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	cmd_t       cmd_in;
	logic       wr_en;
	logic       rd_en;

	// classify the incoming byte
	always_comb begin
		cmd_in.skip  = SKIP_W'((code_byte & SKIP_MASK) >> SKIP_SHIFT);
		cmd_in.color = COLOR_W'(code_byte & COLOR_MASK);
	end

	assign full      = (count_q == 2'd2);
	assign cmd_valid = (count_q != 2'd0);
	assign cmd       = q_mem_q[rd_ptr_q];
	assign wr_en     = push && !full;
	assign rd_en     = cmd_take && cmd_valid;

	// queue storage
	always_ff @(posedge clk) begin
		if (wr_en) begin
			q_mem_q[wr_ptr_q] <= cmd_in;
		end
	end

	// queue pointers and fill
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (rd_en) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + 2'd1;
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

`default_nettype wire

// ===== src/gscrd_back.sv =====
// ----------------------------------------------------------------------------
// gscrd_back
// expands commands into pixels, tracks box position, queues pixels out
// ----------------------------------------------------------------------------
`default_nettype none

module gscrd_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire gscrd_pkg::box_cfg_t box_cfg,
	input  wire gscrd_pkg::cmd_t   cmd,
	input  wire logic              cmd_valid,
	output logic                   cmd_take,
	output gscrd_pkg::pixel_t      pix_head,
	output logic                   empty,
	input  wire logic              pop
);
	import gscrd_pkg::*;

	logic               busy_q;
	logic [SKIP_W-1:0]  idx_q;
	logic [SKIP_W-1:0]  skip_q;
	logic [COLOR_W-1:0] color_q;
	logic [COORD_W-1:0] col_q;
	logic [COORD_W-1:0] row_q;

	pixel_t             out_mem_q [2];
	logic               out_wr_ptr_q;
	logic               out_rd_ptr_q;
	logic [1:0]         out_count_q;

	logic [COORD_W-1:0] w_m1;
	logic [COORD_W-1:0] h_m1;
	logic               last_col;
	logic               glyph_end;
	logic               final_pix;
	logic               emit;
	logic               out_pop;
	pixel_t             pix;

	// last column and row, zero size acting as one
	assign w_m1 = (box_cfg.width  == '0) ? '0 : box_cfg.width  - COORD_W'(1);
	assign h_m1 = (box_cfg.height == '0) ? '0 : box_cfg.height - COORD_W'(1);

	assign last_col  = (col_q >= w_m1);
	assign glyph_end = last_col && (row_q >= h_m1);
	assign final_pix = (idx_q == skip_q);

	assign emit     = busy_q && (out_count_q != 2'd2);
	assign cmd_take = !busy_q && cmd_valid;
	assign out_pop  = pop && !empty;

	// pixel being produced
	always_comb begin
		pix.x     = box_cfg.x_off + col_q;
		pix.y     = box_cfg.y_off + row_q;
		pix.color = final_pix ? color_q : '0;
		pix.last  = glyph_end || final_pix;
		pix.done  = glyph_end;
	end

	// command registers
	always_ff @(posedge clk) begin
		if (cmd_take) begin
			skip_q  <= cmd.skip;
			color_q <= cmd.color;
		end
	end

	// run counter and box position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
			col_q  <= '0;
			row_q  <= '0;
		end else begin
			if (cmd_take) begin
				busy_q <= 1'b1;
				idx_q  <= '0;
			end else if (emit) begin
				if (pix.last) begin
					busy_q <= 1'b0;
				end else begin
					idx_q <= idx_q + SKIP_W'(1);
				end
				if (glyph_end) begin
					col_q <= '0;
					row_q <= '0;
				end else if (last_col) begin
					col_q <= '0;
					row_q <= row_q + COORD_W'(1);
				end else begin
					col_q <= col_q + COORD_W'(1);
				end
			end
		end
	end

	// output queue storage
	always_ff @(posedge clk) begin
		if (emit) begin
			out_mem_q[out_wr_ptr_q] <= pix;
		end
	end

	// output queue pointers and fill
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_wr_ptr_q <= 1'b0;
			out_rd_ptr_q <= 1'b0;
			out_count_q  <= 2'd0;
		end else begin
			if (emit) begin
				out_wr_ptr_q <= !out_wr_ptr_q;
			end
			if (out_pop) begin
				out_rd_ptr_q <= !out_rd_ptr_q;
			end
			if (emit && !out_pop) begin
				out_count_q <= out_count_q + 2'd1;
			end else if (out_pop && !emit) begin
				out_count_q <= out_count_q - 2'd1;
			end
		end
	end

	assign empty    = (out_count_q == 2'd0);
	assign pix_head = out_mem_q[out_rd_ptr_q];

endmodule

`default_nettype wire

// ===== src/glyph_skip_color_rle_decoder.sv =====
// ----------------------------------------------------------------------------
// glyph_skip_color_rle_decoder
// turns skip/colour code bytes into positioned pixels inside a glyph box
//
//   channel   direction  handshake            payload
//   code      in         push / full          code_byte
//   pixel     out        empty / pop          pixel_x pixel_y pixel_color
//                                             last_of_byte glyph_done
//   config    in         cfg_valid/cfg_ready  cfg_index cfg_data
//
// a byte is loaded into the expander, which then gives one pixel per cycle
// while the pixel queue, drained by pop, has room: 1 to 32 pixels, fewer if
// the box fills first; the pixel counter in the back end sets this. two
// bytes queue ahead of it and two pixels behind it. reset is immediate: no
// clearing pass, box counters start at zero.
// ----------------------------------------------------------------------------
`default_nettype none

`include "glyph_skip_color_rle_decoder_macros.svh"

module glyph_skip_color_rle_decoder (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            push,
	output logic                                 full,
	input  wire logic [7:0]                      code_byte,
	output logic                                 empty,
	input  wire logic                            pop,
	output logic [7:0]                           pixel_x,
	output logic [7:0]                           pixel_y,
	output logic [2:0]                           pixel_color,
	output logic                                 last_of_byte,
	output logic                                 glyph_done,
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [gscrd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [7:0]                      cfg_data
);
	import gscrd_pkg::*;

	box_cfg_t  box_cfg_q;
	cmd_t      cmd;
	logic      cmd_valid;
	logic      cmd_take;
	pixel_t    pix_head;

	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_cfg_q.width  <= 8'd1;
			box_cfg_q.height <= 8'd1;
			box_cfg_q.x_off  <= 8'd0;
			box_cfg_q.y_off  <= 8'd0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_BOX_WIDTH:    box_cfg_q.width  <= cfg_data;
				REG_BOX_HEIGHT:   box_cfg_q.height <= cfg_data;
				REG_BOX_X_OFFSET: box_cfg_q.x_off  <= cfg_data;
				REG_BOX_Y_OFFSET: box_cfg_q.y_off  <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// byte intake and classification
	gscrd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.code_byte (code_byte),
		.cmd       (cmd),
		.cmd_valid (cmd_valid),
		.cmd_take  (cmd_take)
	);

	// pixel expansion
	gscrd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.box_cfg   (box_cfg_q),
		.cmd       (cmd),
		.cmd_valid (cmd_valid),
		.cmd_take  (cmd_take),
		.pix_head  (pix_head),
		.empty     (empty),
		.pop       (pop)
	);

	// result ports
	assign pixel_x      = pix_head.x;
	assign pixel_y      = pix_head.y;
	assign pixel_color  = pix_head.color;
	assign last_of_byte = pix_head.last;
	assign glyph_done   = pix_head.done;

	// checks
	`GSCRD_ASSERT_IMP(a_done_ends_byte, !empty && glyph_done, last_of_byte, "done without last")
	`GSCRD_ASSERT_IMP(a_skip_is_clear, !empty && !last_of_byte, pixel_color == 3'd0, "early colour")
	`GSCRD_ASSERT_IMP(a_take_needs_cmd, cmd_take, cmd_valid, "take from empty queue")
	`GSCRD_ASSERT_NXT(a_reset_empty, !arst_n, empty && !full, "queues not empty after reset")

endmodule

`default_nettype wire

// ===== dv/glyph_skip_color_rle_decoder_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glyph_skip_color_rle_decoder_tb
// Drives skip/colour code bytes through the decoder under several box settings.
// A scoreboard class expands each accepted byte into the pixels it should give.
// Every popped pixel is checked against the oldest one still waiting.
// Both sides idle at random. The box is reprogrammed only once the block has drained.
// ----------------------------------------------------------------------------
`default_nettype none

module glyph_skip_color_rle_decoder_tb;

	import gscrd_pkg::*;

	// expands code bytes into expected pixels and checks the popped ones
	class pixel_scoreboard;
		pixel_t pixel_q[$];
		int unsigned errors;
		logic [7:0] width, height, x_off, y_off;
		logic [7:0] col, row;

		function new();
			width  = 8'd1;
			height = 8'd1;
			x_off  = 8'd0;
			y_off  = 8'd0;
			col    = 8'd0;
			row    = 8'd0;
			errors = 0;
		endfunction

		function void set_reg(cfg_reg_t idx, logic [7:0] v);
			case (idx)
				REG_BOX_WIDTH:    width  = v;
				REG_BOX_HEIGHT:   height = v;
				REG_BOX_X_OFFSET: x_off  = v;
				REG_BOX_Y_OFFSET: y_off  = v;
				default: ;
			endcase
		endfunction

		// skip run of transparent pixels, then one coloured pixel
		function void note_code(logic [7:0] code);
			logic [4:0] skip;
			logic [2:0] colour;
			int unsigned w, h;
			logic last_col, done;
			pixel_t px;
			skip   = code[7:SKIP_SHIFT];
			colour = code[COLOR_W-1:0];
			w = (width == 8'd0) ? 1 : width;
			h = (height == 8'd0) ? 1 : height;
			for (int i = 0; i <= int'(skip); i++) begin
				last_col = (int'(col) + 1 >= w);
				done     = last_col && (int'(row) + 1 >= h);
				px.x     = x_off + col;
				px.y     = y_off + row;
				px.color = (i == int'(skip)) ? colour : '0;
				px.last  = done || (i == int'(skip));
				px.done  = done;
				pixel_q  = {pixel_q, px};
				// box filled: the rest of the byte is dropped
				if (done) begin
					col = 8'd0;
					row = 8'd0;
					break;
				end
				if (last_col) begin
					col = 8'd0;
					row = row + 8'd1;
				end else begin
					col = col + 8'd1;
				end
			end
		endfunction

		task report(string what, int unsigned got, int unsigned want);
			errors++;
			$display("%0t mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
		endtask

		task check_pixel(pixel_t got);
			pixel_t want;
			if (pixel_q.size() == 0) begin
				report("unexpected pixel x", got.x, 0);
				return;
			end
			want = pixel_q.pop_front();
			if (got.x !== want.x)         report("pixel_x", got.x, want.x);
			if (got.y !== want.y)         report("pixel_y", got.y, want.y);
			if (got.color !== want.color) report("pixel_color", got.color, want.color);
			if (got.last !== want.last)   report("last_of_byte", got.last, want.last);
			if (got.done !== want.done)   report("glyph_done", got.done, want.done);
		endtask

		function int unsigned pending();
			return pixel_q.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic [7:0] code_byte = 8'd0;
	logic pop = 1'b0;
	logic cfg_valid = 1'b0;
	cfg_reg_t cfg_index = REG_BOX_WIDTH;
	logic [7:0] cfg_data = 8'd0;
	logic full, empty, cfg_ready;
	logic [7:0] pixel_x, pixel_y;
	logic [2:0] pixel_color;
	logic last_of_byte, glyph_done;

	int unsigned idle_pct = 18;
	pixel_scoreboard sb = new();

	glyph_skip_color_rle_decoder DUT (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.code_byte(code_byte),
		.empty(empty),
		.pop(pop),
		.pixel_x(pixel_x),
		.pixel_y(pixel_y),
		.pixel_color(pixel_color),
		.last_of_byte(last_of_byte),
		.glyph_done(glyph_done),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// clock
	initial begin
		forever #5 clk = ~clk;
	end

	// watchdog
	initial begin
		#2_000_000;
		$display("glyph_skip_color_rle_decoder_tb: errors");
		$finish;
	end

	// pixel side: check on accept, random pop
	always @(posedge clk) begin
		if (arst_n) begin
			if (pop && !empty)
				sb.check_pixel('{x: pixel_x, y: pixel_y, color: pixel_color,
					last: last_of_byte, done: glyph_done});
			pop <= ($urandom_range(0, 99) >= idle_pct);
		end
	end

	// one code item, with random idle cycles ahead of it
	task send_code(logic [7:0] b);
		while ($urandom_range(0, 99) < idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		code_byte <= b;
		do @(posedge clk); while (full);
		sb.note_code(b);
	endtask

	// hold off the sender until every pixel is out and the expander is quiet
	task drain();
		push <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task write_reg(cfg_reg_t idx, logic [7:0] v);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		sb.set_reg(idx, v);
	endtask

	task set_box(logic [7:0] w, logic [7:0] h, logic [7:0] xo, logic [7:0] yo);
		drain();
		write_reg(REG_BOX_WIDTH, w);
		write_reg(REG_BOX_HEIGHT, h);
		write_reg(REG_BOX_X_OFFSET, xo);
		write_reg(REG_BOX_Y_OFFSET, yo);
		cfg_valid <= 1'b0;
	endtask

	function logic [7:0] rand_code();
		if ($urandom_range(0, 1) == 0)
			return 8'($urandom_range(0, 255));
		// short skips so that glyphs complete often
		return {5'($urandom_range(0, 3)), 3'($urandom_range(0, 7))};
	endfunction

	// main sequence
	initial begin
		logic [7:0] w, h;
		int unsigned r;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset box of one pixel, long skip overruns at once
		send_code(8'h00);
		send_code(8'hFF);
		send_code(8'h07);

		// small box, overrun on a long skip
		set_box(8'd4, 8'd3, 8'd0, 8'd0);
		send_code(8'h01);
		send_code(8'h0A);
		send_code(8'hF8);
		send_code(8'h13);
		send_code(8'h7E);

		// box shrunk mid-glyph past both the last row and column
		set_box(8'd6, 8'd4, 8'd0, 8'd0);
		send_code(8'hA0);
		set_box(8'd2, 8'd2, 8'd0, 8'd0);
		send_code(8'h05);

		// box narrowed mid-glyph, column wraps to the next row
		set_box(8'd8, 8'd8, 8'd0, 8'd0);
		send_code(8'h68);
		set_box(8'd4, 8'd8, 8'd0, 8'd0);
		send_code(8'h11);
		send_code(8'hF2);

		// coordinate wrap past 255
		set_box(8'd10, 8'd10, 8'd250, 8'd254);
		send_code(8'hFF);
		send_code(8'hFF);
		send_code(8'hFF);
		send_code(8'h7C);

		// zero size acts as one
		set_box(8'd0, 8'd0, 8'd255, 8'd255);
		send_code(8'h1B);
		send_code(8'h06);

		// largest box
		set_box(8'd255, 8'd255, 8'd0, 8'd0);
		send_code(8'hFF);
		send_code(8'hFF);
		send_code(8'h86);

		// random segments, each under a fresh box
		for (int seg = 0; seg < 6; seg++) begin
			r = $urandom_range(0, 9);
			w = (r == 0) ? 8'd0 : (r == 1) ? 8'd255 : 8'($urandom_range(1, 12));
			r = $urandom_range(0, 9);
			h = (r == 0) ? 8'd0 : (r == 1 && w != 8'd255) ? 8'd255 :
				8'($urandom_range(1, 8));
			set_box(w, h, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
			// one segment with no idling on either side
			idle_pct = (seg == 2) ? 0 : 18;
			for (int k = 0; k < 50; k++)
				send_code(rand_code());
		end
		idle_pct = 18;

		drain();
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("glyph_skip_color_rle_decoder_tb: clean");
		end else begin
			$display("glyph_skip_color_rle_decoder_tb: errors");
		end
		$finish;
	end

endmodule

`default_nettype wire

// ===== filelist.f =====
+incdir+src
src/gscrd_pkg.sv
src/gscrd_front.sv
src/gscrd_back.sv
src/glyph_skip_color_rle_decoder.sv
dv/glyph_skip_color_rle_decoder_tb.sv
